/* hw/rtl/boxb_pkg.sv */
// ----------------------------------------------------------------------------
// boxb_pkg: shared types, constants and helpers of the 3x3 box blur
// Frame limits, register indexes, channel sum types and the divide-by-nine
// used by the filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package boxb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // Widths that follow from the frame limits.
    localparam int COL_W   = $clog2(MAX_WIDTH);       // column index
    localparam int ROW_W   = $clog2(MAX_HEIGHT);      // row index
    localparam int WIDTH_W = $clog2(MAX_WIDTH) + 1;   // image width / lag
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT) + 1; // image height

    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 12;                   // up to 9 * 255

    // Configuration register indexes.
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reciprocal of nine scaled by 2^16; exact floor for sums up to 9 * 255.
    localparam logic [12:0] RECIP_NINE = 13'd7282;

    typedef logic [3:0][SUM_W-1:0] t_chan_sums;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
        logic [SUM_W+12:0] prod;
        prod = sum * RECIP_NINE;
        return prod[23:16];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/boxb_line_ram.sv */
// ----------------------------------------------------------------------------
// boxb_line_ram: simple dual-port line buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module boxb_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/boxb_mean.sv */
// ----------------------------------------------------------------------------
// boxb_mean: per-channel mean of the window or border copy
// Divides each channel sum by nine and picks the center pixel on borders.
// ----------------------------------------------------------------------------
`default_nettype none

module boxb_mean
    import boxb_pkg::*;
(
    input  wire  t_chan_sums  i_sums,
    input  wire  [31:0]       i_center,
    input  wire               i_border,
    output logic [31:0]       o_pixel
);

    logic [31:0] mean_pix;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mean_pix[8*k +: 8] = div9(i_sums[k]);
        end
    end

    assign o_pixel = i_border ? i_center : mean_pix;

endmodule

`default_nettype wire

/* hw/rtl/box_blur_3x3_rgba.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba: streaming 3x3 box blur for RGBA pixels
// Keeps two image rows in a line memory and a 3x3 window in registers.
// ----------------------------------------------------------------------------
// Usage:
// Pixels of one frame enter in raster order on the s_axis channel, one
// transaction per pixel; tuser set marks a drain transaction whose pixel is
// ignored. Every input transaction yields exactly one m_axis transaction.
// tuser on the output says whether tdata carries a frame pixel; tlast marks
// the last pixel of a frame. Interior pixels become the truncated mean of
// their 3x3 neighborhood per 8-bit channel; border pixels pass unchanged.
// A pixel's result comes out image_width + 1 transactions after the pixel
// itself, so image_width + 1 drain transactions flush the end of a frame.
// Inside the block an item goes from accept to the output register through
// the line memory read, the window update with channel sums, and the
// divide/select stage. One item is accepted per cycle without back-pressure;
// the limit is the single read and single write of the line memory per pixel.
// When the receiver stalls, the output register holds and the stages behind
// it fill up; s_axis_tready drops only once all three stages are full.
// Reset is synchronous and clears the counters, stage valids and window; the line
// memory needs no clearing pass. Configuration writes restart the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgba
    import boxb_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Configuration write channel.
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [0:0]            i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    // Pixel input stream.
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [31:0]           s_axis_tdata,   // [31:0] pixel_in
    input  wire                   s_axis_tuser,   // [0] drain
    // Pixel output stream.
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [31:0] pixel_out
    output logic                  m_axis_tuser,   // [0] out_valid
    output logic                  m_axis_tlast    // out_last
);

    // Item control and payload carried from accept into the memory stage.
    typedef struct packed {
        logic             push;
        logic             emit;
        logic             border;
        logic             last;
        logic [COL_W-1:0] col;
        logic [31:0]      pix;
    } t_s1;

    // Item carried from the window stage into the divide/select stage.
    typedef struct packed {
        logic        emit;
        logic        border;
        logic        last;
        logic [31:0] center;
        t_chan_sums  sums;
    } t_s2;

    // Configuration registers (raw values as written).
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // Frame position counters.
    logic [COL_W-1:0]    r_in_col, n_in_col;
    logic [WIDTH_W-1:0]  r_lag, n_lag;
    logic [COL_W-1:0]    r_ocol, n_ocol;
    logic [ROW_W-1:0]    r_orow, n_orow;

    // Pipeline stages.
    logic r_v1, r_v2;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;

    logic [31:0] r_win [3][3];
    logic [31:0] n_win [3][3];

    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic                acc, cfg_acc, drain, push, fill_done, emit;
    logic                col_wrap, ocol_end, orow_end, border, last;
    logic                en1, en2, en3;
    logic                ram_we, ram_re;
    logic [63:0]         ram_rd;
    logic [31:0]         top, mid;
    logic [31:0]         mean_pix;

    // Registers below three or above the frame limits are clamped.
    always_comb begin
        priority if (r_width < WIDTH_W'(3)) begin
            w = WIDTH_W'(3);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w = WIDTH_W'(MAX_WIDTH);
        end else begin
            w = r_width;
        end
        priority if (r_height < HEIGHT_W'(3)) begin
            h = HEIGHT_W'(3);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h = r_height;
        end
    end

    // Stage enables: a stage moves when the stage after it is empty or moving.
    assign en3           = !m_axis_tvalid || m_axis_tready;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign o_cfg_ready   = 1'b1;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign drain   = s_axis_tuser;

    // A drain only pushes while results are still owed.
    assign push      = !drain || (r_lag != '0);
    assign fill_done = (r_lag > w);
    assign emit      = push && fill_done;

    assign col_wrap = ({1'b0, r_in_col} == w - WIDTH_W'(1));
    assign ocol_end = ({1'b0, r_ocol} == w - WIDTH_W'(1));
    assign orow_end = ({1'b0, r_orow} == h - HEIGHT_W'(1));
    assign border   = (r_orow == '0) || orow_end || (r_ocol == '0) || ocol_end;
    assign last     = orow_end && ocol_end;

    // Position bookkeeping, settled at accept time.
    always_comb begin
        n_in_col = r_in_col;
        n_lag    = r_lag;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        if (cfg_acc) begin
            n_in_col = '0;
            n_lag    = '0;
            n_ocol   = '0;
            n_orow   = '0;
        end else if (acc && push) begin
            n_in_col = col_wrap ? '0 : r_in_col + COL_W'(1);
            if (!fill_done) begin
                n_lag = r_lag + WIDTH_W'(1);
            end
            if (emit) begin
                if (ocol_end) begin
                    n_ocol = '0;
                    n_orow = last ? '0 : r_orow + ROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
                // A drain that finishes a frame leaves the block idle.
                if (last && drain) begin
                    n_in_col = '0;
                    n_lag    = '0;
                end
            end
        end
    end

    always_comb begin
        n_s1.push   = push;
        n_s1.emit   = emit;
        n_s1.border = border;
        n_s1.last   = last;
        n_s1.col    = r_in_col;
        n_s1.pix    = drain ? 32'd0 : s_axis_tdata;
    end

    // Line memory: each entry holds {row above current, two rows above}.
    assign ram_re = acc && push;
    assign ram_we = en2 && r_v1 && r_s1.push;

    boxb_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (64)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (r_s1.col),
        .i_wr_data ({r_s1.pix, mid}),
        .i_re      (ram_re),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_rd)
    );

    assign top = ram_rd[31:0];
    assign mid = ram_rd[63:32];

    // Window shift and channel sums of the shifted window.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_win[r][c] = r_win[r][c];
            end
        end
        if (r_s1.push) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
            n_win[0][2] = top;
            n_win[1][2] = mid;
            n_win[2][2] = r_s1.pix;
        end
        for (int k = 0; k < 4; k++) begin
            n_s2.sums[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    n_s2.sums[k] = n_s2.sums[k] + SUM_W'(n_win[r][c][8*k +: 8]);
                end
            end
        end
        n_s2.emit   = r_s1.emit;
        n_s2.border = r_s1.border;
        n_s2.last   = r_s1.last;
        n_s2.center = n_win[1][1];
    end

    boxb_mean u_mean (
        .i_sums   (r_s2.sums),
        .i_center (r_s2.center),
        .i_border (r_s2.border),
        .o_pixel  (mean_pix)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= WIDTH_W'(1024);
            r_height      <= HEIGHT_W'(1024);
            r_in_col      <= '0;
            r_lag         <= '0;
            r_ocol        <= '0;
            r_orow        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                    default:          r_width  <= r_width;
                endcase
            end
            r_in_col <= n_in_col;
            r_lag    <= n_lag;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
            if (en1) begin
                r_v1 <= acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                m_axis_tvalid <= r_v2;
            end
        end
    end

    // Window state is cleared by reset; stage payloads are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (en2 && r_v1) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (en2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (en3 && r_v2) begin
            m_axis_tdata <= r_s2.emit ? mean_pix : 32'd0;
            m_axis_tuser <= r_s2.emit;
            m_axis_tlast <= r_s2.emit && r_s2.last;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_lag_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lag <= w + WIDTH_W'(1))
        else $error("lag exceeds image width plus one");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_in_col} < w) && ({1'b0, r_ocol} < w))
        else $error("column counter outside the image row");

    // The same column is read and written together only at a frame start, after a drain
    // or a configuration write has reset the counters; the stale entry then feeds border results alone.
    a_ram_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re && (r_s1.col == r_in_col)) |-> (r_lag == '0))
        else $error("line memory read and write hit the same column inside a frame");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end flagged on a non-pixel result");

    a_emit_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit) |=> (r_v1 && r_s1.push))
        else $error("emitting item entered the pipeline without a push");

endmodule

`default_nettype wire

/* sim/blur_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_checker: scoreboard for the streaming 3x3 RGBA box blur
// Watches the configuration, pixel input and pixel output channels, keeps
// its own model of the line rows, the 3x3 window and the frame counters, and
// compares every output transaction with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module blur_checker
    import boxb_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [0:0]            i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  s_axis_tvalid,
    input  wire                  s_axis_tready,
    input  wire [31:0]           s_axis_tdata,
    input  wire                  s_axis_tuser,
    input  wire                  m_axis_tvalid,
    input  wire                  m_axis_tready,
    input  wire [31:0]           m_axis_tdata,
    input  wire                  m_axis_tuser,
    input  wire                  m_axis_tlast,
    output int                   o_error_count,
    output int                   o_pending
);

    localparam int WINDOW_TAPS = 9;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [31:0] pixel;
        logic        valid;
        logic        last;
    } t_blur_result;

    logic [11:0]         reg_width;
    logic [12:0]         reg_height;
    logic [31:0]         upper_line [MAX_WIDTH];   // two rows above the input row
    logic [31:0]         lower_line [MAX_WIDTH];   // one row above the input row
    logic [31:0]         win [3][3];
    logic [WIDTH_W-1:0]  push_col;
    logic [HEIGHT_W-1:0] push_row;
    logic [WIDTH_W-1:0]  backlog;                   // pushes not yet answered
    logic [23:0]         emit_index;                // raster index of next output
    t_blur_result        expected_pixels [$];
    int                  errors;

    function automatic logic [31:0] window_mean();
        logic [SUM_W-1:0] acc;
        logic [31:0]      result;
        result = '0;
        for (int ch = 0; ch < 4; ch++) begin
            acc = '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    acc += SUM_W'(win[r][c][8*ch +: 8]);
            result[8*ch +: 8] = 8'(acc / SUM_W'(WINDOW_TAPS));
        end
        return result;
    endfunction

    // Advances the model by one input transaction and returns its output.
    task automatic blur_push(input logic [31:0] pix, input logic drn,
                             output t_blur_result res);
        int unsigned w, h, total, col, orow, ocol;
        logic [31:0] fresh, top_px, mid_px;
        w = (reg_width < 3) ? 3 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
        h = (reg_height < 3) ? 3 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
        total = w * h;
        res = '0;
        // A drain with nothing in flight is ignored altogether.
        if (drn && backlog == 0)
            return;
        fresh = drn ? 32'h0 : pix;
        col = (push_col >= MAX_WIDTH) ? 0 : push_col;
        top_px = upper_line[col];
        mid_px = lower_line[col];
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = fresh;
        upper_line[col] = mid_px;
        lower_line[col] = fresh;
        push_col = push_col + 1;
        if (push_col >= w) begin
            push_col = '0;
            push_row = push_row + 1;
            if (push_row >= h)
                push_row = '0;
        end
        if (backlog < w + 1) begin
            backlog = backlog + 1;
            return;
        end
        if (emit_index >= total)
            emit_index = '0;
        orow = emit_index / w;
        ocol = emit_index % w;
        if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1)
            res.pixel = win[1][1];
        else
            res.pixel = window_mean();
        res.valid = 1'b1;
        res.last  = (emit_index == total - 1);
        emit_index = emit_index + 1;
        if (emit_index >= total) begin
            emit_index = '0;
            // A frame closed by a drain leaves the block idle.
            if (drn) begin
                push_col = '0;
                push_row = '0;
                backlog  = '0;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field, want, seen);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_blur_result predicted;
        t_blur_result oldest;
        if (!i_rst_n) begin
            reg_width  = 12'd1024;
            reg_height = 13'd1024;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                upper_line[k] = '0;
                lower_line[k] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            push_col   = '0;
            push_row   = '0;
            backlog    = '0;
            emit_index = '0;
            expected_pixels.delete();
            errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_IMAGE_WIDTH)
                    reg_width = i_cfg_data[11:0];
                else if (i_cfg_index == REG_IMAGE_HEIGHT)
                    reg_height = i_cfg_data[12:0];
                push_col   = '0;
                push_row   = '0;
                backlog    = '0;
                emit_index = '0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                blur_push(s_axis_tdata, s_axis_tuser, predicted);
                expected_pixels.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: unexpected output, expected none, actual %h/%b/%b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    oldest = expected_pixels.pop_front();
                    check_field("pixel_out", oldest.pixel, m_axis_tdata);
                    check_field("out_valid", oldest.valid, m_axis_tuser);
                    check_field("out_last", oldest.last, m_axis_tlast);
                end
            end
        end
        o_error_count <= errors;
        o_pending     <= expected_pixels.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the streaming 3x3 RGBA box blur
// Drives configuration writes and pixel/drain transactions with bursty input
// and a stalling receiver; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import boxb_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 800;
    localparam int WIDE_ITEMS    = 300;   // opening part of the widest frame
    localparam int PHASE_BUDGET  = 300;   // items per random configuration
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int HOLD_PHASE    = 3;     // random phase that gets the hold-off
    localparam int SETTLE_CYCLES = 8;     // pipeline is three stages deep
    localparam int FINAL_CYCLES  = 20;

    // Receiver behavior; the receiver picks a new mode at random.
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} t_rx_mode;
    // Pixel content of a frame.
    typedef enum int {PIX_RANDOM, PIX_SATURATED, PIX_MIXED} t_pix_style;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [0:0]            i_cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int       error_count;
    int       pending_count;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    logic     hold_request = 1'b0;

    // Receiver state, owned by the receiver process.
    t_rx_mode rx_mode      = RX_OPEN;
    int       mode_left    = 0;
    int       hold_count   = 0;
    logic [7:0] stall_mask = 8'hFF;
    logic [2:0] mask_pos   = '0;

    box_blur_3x3_rgba u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] pixel_in
        .s_axis_tuser  (s_axis_tuser),   // [0] drain
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] pixel_out
        .m_axis_tuser  (m_axis_tuser),   // [0] out_valid
        .m_axis_tlast  (m_axis_tlast)    // out_last
    );

    blur_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver. Once the stimulus raises hold_request, tready is held low long
    // enough that the output register and the stages behind it fill and the
    // block has to back-pressure its input. Otherwise it switches between
    // always ready, light and heavy random stalls, and a repeating stall
    // pattern from a random mask.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_request && hold_count < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_count++;
        end else begin
            if (mode_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 96);
                stall_mask = $urandom;
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:  m_axis_tready <= 1'b1;
                RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    m_axis_tready <= stall_mask[mask_pos];
                    mask_pos = mask_pos + 1;
                end
            endcase
        end
    end

    function automatic int unsigned clamp_size(input int unsigned value,
                                               input int unsigned lo,
                                               input int unsigned hi);
        return (value < lo) ? lo : (value > hi) ? hi : value;
    endfunction

    function automatic logic [31:0] make_pixel(input t_pix_style style);
        logic [31:0] p;
        p = $urandom;
        case (style)
            // Mostly full-scale channels: the largest window sums.
            PIX_SATURATED: p = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            PIX_MIXED: begin
                for (int b = 0; b < 4; b++)
                    case ($urandom_range(0, 2))
                        0:       p[8*b +: 8] = 8'h00;
                        1:       p[8*b +: 8] = 8'hFF;
                        default: p[8*b +: 8] = $urandom_range(0, 255);
                    endcase
            end
            default: ;
        endcase
        return p;
    endfunction

    // One register write; valid is dropped after the transaction.
    task automatic write_register(input logic [0:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One input transaction. The sender runs in bursts; when a burst runs out,
    // tvalid drops for a random gap before the next item, so a lowered tvalid
    // is never raised again within the same time step.
    task automatic send_item(input logic [31:0] pix, input logic drn);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= drn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Stops the input stream and waits until every predicted output has come
    // back, then lets the pipeline settle, so that the block is idle for a write.
    task automatic wait_drained();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sends up to one frame of pixels in raster order. Now and then a drain
    // stands in for a pixel, which the block treats as a zero pixel while results are owed.
    task automatic send_frame(input int unsigned cols, input int unsigned rows,
                              input t_pix_style style, input int unsigned budget,
                              output int unsigned sent);
        int unsigned count;
        count = cols * rows;
        if (count > budget)
            count = budget;
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 39) == 0)
                send_item($urandom, 1'b1);
            else
                send_item(make_pixel(style), 1'b0);
        end
        sent = count;
    endtask

    initial begin
        int unsigned w_val, h_val, w_eff, h_eff, drains, sent;
        int unsigned total_random, phase_items, frame_count;
        int          phase_count;
        total_random = 0;
        phase_count  = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A drain right after reset finds the block idle and
        // must come back as an empty result.
        send_item(32'hA5A5_5A5A, 1'b1);
        wait_drained();

        // Out-of-range sizes clamp to the 3x3 minimum frame.
        write_register(REG_IMAGE_WIDTH, 13'd0);
        write_register(REG_IMAGE_HEIGHT, 13'd2);
        // One black corner and full-scale pixels, with the last position given
        // by a drain, so the single interior pixel averages 0, seven 255s and 0.
        send_item(32'h0000_0000, 1'b0);
        repeat (7) send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        // Flush with width + 1 drains; the last one closes the frame, and the
        // drain after it finds the block idle again.
        repeat (4) send_item(32'h0000_0000, 1'b1);
        send_item(32'h1234_5678, 1'b1);
        wait_drained();

        // Widest frame (all ones clamps to the maximum width): the opening part
        // of its first row, where every result is still empty while the
        // window fills.
        write_register(REG_IMAGE_HEIGHT, 13'd3);
        write_register(REG_IMAGE_WIDTH, 13'h1FFF);
        repeat (WIDE_ITEMS) send_item($urandom, 1'b0);
        wait_drained();

        // Tallest frame, only its first rows.
        write_register(REG_IMAGE_WIDTH, 13'd3);
        write_register(REG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (40) send_item($urandom, 1'b0);
        wait_drained();

        // Random part: a new frame size per phase, mostly small, with frames (cut
        // at the phase budget) that either run back to back or are flushed by
        // drains. Some flushes are cut short or overrun into idle drains.
        while (total_random < RANDOM_ITEMS) begin
            phase_count++;
            case ($urandom_range(0, 9))
                0:       w_val = $urandom_range(0, 2);
                1:       w_val = $urandom_range(11, 40);
                default: w_val = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0:       h_val = $urandom_range(0, 2);
                1:       h_val = $urandom_range(0, 8191);
                default: h_val = $urandom_range(3, 8);
            endcase
            w_eff = clamp_size(w_val & 32'hFFF, 3, MAX_WIDTH);
            h_eff = clamp_size(h_val & 32'h1FFF, 3, MAX_HEIGHT);
            if ($urandom_range(0, 1)) begin
                write_register(REG_IMAGE_WIDTH, w_val);
                write_register(REG_IMAGE_HEIGHT, h_val);
            end else begin
                write_register(REG_IMAGE_HEIGHT, h_val);
                write_register(REG_IMAGE_WIDTH, w_val);
            end
            if (phase_count == HOLD_PHASE)
                hold_request <= 1'b1;

            phase_items = 0;
            frame_count = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frame_count && phase_items < PHASE_BUDGET; f++) begin
                send_frame(w_eff, h_eff, t_pix_style'($urandom_range(0, 2)),
                           PHASE_BUDGET - phase_items, sent);
                phase_items += sent;
                if (f == frame_count - 1 || $urandom_range(0, 1)) begin
                    case ($urandom_range(0, 5))
                        0:       drains = $urandom_range(1, w_eff);
                        1:       drains = w_eff + 1 + $urandom_range(1, 3);
                        default: drains = w_eff + 1;
                    endcase
                    repeat (drains) send_item($urandom, 1'b1);
                    phase_items += (drains > w_eff + 1) ? w_eff + 1 : drains;
                end
            end
            total_random += phase_items;
            wait_drained();
        end

        repeat (FINAL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
